/* hw/rtl/lpst_pkg.sv */
// Shared types, codes and default sizes for the linear prime sieve table.
package lpst_pkg;

    localparam int DEF_VALUE_LIMIT = 65536;
    localparam int DEF_PRIME_SLOTS = 8192;

    localparam int CFG_W   = 17;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 14;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 17'd65536;

    typedef enum logic
    {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_NOT_BUILT = 2'd1,
        STATUS_RANGE     = 2'd2,
        STATUS_BUILT     = 2'd3
    } status_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_QUERY,
        ST_CLEAR,
        ST_RD_I,
        ST_CHK,
        ST_RD_P,
        ST_MUL,
        ST_MARK,
        ST_NEXT
    } state_t;

    typedef struct packed
    {
        status_t              status;
        logic [COUNT_W-1:0]   count;
        logic [VALUE_W-1:0]   factor;
    } res_t;

endpackage

/* hw/rtl/lpst_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
module lpst_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/lpst_ctrl.sv */
// Sequencer and table memories of the sieve: clear sweep, linear sieve and lookups.
module lpst_ctrl #(
    parameter int VALUE_LIMIT = lpst_pkg::DEF_VALUE_LIMIT,
    parameter int PRIME_SLOTS = lpst_pkg::DEF_PRIME_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lpst_pkg::opcode_t            opcode,
    input  logic [lpst_pkg::VALUE_W-1:0] query_value,
    input  logic [lpst_pkg::CFG_W-1:0]   sieve_limit,
    input  logic                         out_free,
    output logic                         res_valid,
    output lpst_pkg::res_t               res
);

    import lpst_pkg::*;

    localparam int AW  = $clog2(VALUE_LIMIT);
    localparam int LW  = $clog2(VALUE_LIMIT + 1);
    localparam int PW  = $clog2(PRIME_SLOTS);
    localparam int SCW = $clog2(PRIME_SLOTS + 1);
    localparam int MW  = (LW < CFG_W) ? LW : CFG_W;
    localparam int PRW = 2 * MW;
    localparam int EW  = (LW > CFG_W) ? LW : CFG_W;
    localparam int QW  = (LW > VALUE_W) ? LW : VALUE_W;

    state_t             state_reg, state_next;
    logic [LW-1:0]      i_reg, i_next;
    logic [LW-1:0]      lim_reg, lim_next;
    logic [LW-1:0]      built_lim_reg, built_lim_next;
    logic               built_reg, built_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [SCW-1:0]     stored_reg, stored_next;
    logic [PW-1:0]      j_reg, j_next;
    logic [AW-1:0]      f_reg, f_next;
    logic [AW-1:0]      p_reg, p_next;
    logic [PRW-1:0]     prod_reg, prod_next;

    logic               fac_we, fac_re, cnt_we, cnt_re, prm_we, prm_re;
    logic [AW-1:0]      fac_waddr, fac_raddr, cnt_waddr;
    logic [AW-1:0]      fac_wdata, fac_rdata;
    logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
    logic [PW-1:0]      prm_waddr, prm_raddr;
    logic [AW-1:0]      prm_wdata, prm_rdata;

    logic [LW-1:0]      eff_lim;
    logic [SCW-1:0]     stored_after;
    logic [AW-1:0]      f_cur;
    logic               is_prime;

    // The limit saturates into 2 .. VALUE_LIMIT when a build starts.
    always_comb
    begin
        if (sieve_limit < CFG_W'(2))
        begin
            eff_lim = LW'(2);
        end
        else if (EW'(sieve_limit) > EW'(VALUE_LIMIT))
        begin
            eff_lim = LW'(VALUE_LIMIT);
        end
        else
        begin
            eff_lim = LW'(sieve_limit);
        end
    end

    lpst_ram #(.DEPTH(VALUE_LIMIT), .WIDTH(AW)) u_factor (
        .clk   (clk),
        .we    (fac_we),
        .waddr (fac_waddr),
        .wdata (fac_wdata),
        .re    (fac_re),
        .raddr (fac_raddr),
        .rdata (fac_rdata)
    );

    lpst_ram #(.DEPTH(VALUE_LIMIT), .WIDTH(COUNT_W)) u_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (fac_raddr),
        .rdata (cnt_rdata)
    );

    lpst_ram #(.DEPTH(PRIME_SLOTS), .WIDTH(AW)) u_primes (
        .clk   (clk),
        .we    (prm_we),
        .waddr (prm_waddr),
        .wdata (prm_wdata),
        .re    (prm_re),
        .raddr (prm_raddr),
        .rdata (prm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            built_reg     <= 1'b0;
            built_lim_reg <= '0;
            total_reg     <= '0;
            stored_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            built_lim_reg <= built_lim_next;
            total_reg     <= total_next;
            stored_reg    <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        lim_reg  <= lim_next;
        j_reg    <= j_next;
        f_reg    <= f_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        lim_next       = lim_reg;
        built_lim_next = built_lim_reg;
        built_next     = built_reg;
        total_next     = total_reg;
        stored_next    = stored_reg;
        j_next         = j_reg;
        f_next         = f_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;

        in_ready   = 1'b0;
        res_valid  = 1'b0;
        res        = '{status: STATUS_OK, count: '0, factor: '0};

        fac_we     = 1'b0;
        fac_waddr  = AW'(i_reg);
        fac_wdata  = '0;
        fac_re     = 1'b0;
        fac_raddr  = AW'(i_reg);
        cnt_we     = 1'b0;
        cnt_waddr  = AW'(i_reg);
        cnt_wdata  = '0;
        cnt_re     = 1'b0;
        prm_we     = 1'b0;
        prm_waddr  = PW'(stored_reg);
        prm_wdata  = AW'(i_reg);
        prm_re     = 1'b0;
        prm_raddr  = j_reg;

        is_prime     = (fac_rdata == '0);
        f_cur        = is_prime ? AW'(i_reg) : fac_rdata;
        stored_after = stored_reg;
        if (is_prime && (stored_reg != SCW'(PRIME_SLOTS)))
        begin
            stored_after = stored_reg + SCW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    if (opcode == OP_BUILD)
                    begin
                        lim_next    = eff_lim;
                        i_next      = '0;
                        total_next  = '0;
                        stored_next = '0;
                        state_next  = ST_CLEAR;
                    end
                    else if (!built_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_NOT_BUILT;
                    end
                    else if (QW'(query_value) >= QW'(built_lim_reg))
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_RANGE;
                    end
                    else
                    begin
                        fac_re     = 1'b1;
                        cnt_re     = 1'b1;
                        fac_raddr  = AW'(query_value);
                        state_next = ST_QUERY;
                    end
                end
            end

            ST_QUERY:
            begin
                res_valid  = 1'b1;
                res.status = STATUS_OK;
                res.count  = cnt_rdata;
                res.factor = VALUE_W'(fac_rdata);
                state_next = ST_IDLE;
            end

            ST_CLEAR:
            begin
                fac_we = 1'b1;
                cnt_we = 1'b1;
                if (i_reg == lim_reg - LW'(1))
                begin
                    if (lim_reg == LW'(2))
                    begin
                        built_next     = 1'b1;
                        built_lim_next = lim_reg;
                        res_valid      = 1'b1;
                        res.status     = STATUS_BUILT;
                        res.count      = total_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = LW'(2);
                        state_next = ST_RD_I;
                    end
                end
                else
                begin
                    i_next = i_reg + LW'(1);
                end
            end

            ST_RD_I:
            begin
                fac_re     = 1'b1;
                state_next = ST_CHK;
            end

            ST_CHK:
            begin
                f_next = f_cur;
                if (is_prime)
                begin
                    fac_we    = 1'b1;
                    fac_wdata = AW'(i_reg);
                    prm_we    = (stored_reg != SCW'(PRIME_SLOTS));
                end
                total_next  = total_reg + COUNT_W'(is_prime);
                cnt_we      = 1'b1;
                cnt_wdata   = total_reg + COUNT_W'(is_prime);
                stored_next = stored_after;
                j_next      = '0;
                state_next  = (stored_after == '0) ? ST_NEXT : ST_RD_P;
            end

            ST_RD_P:
            begin
                prm_re     = 1'b1;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                p_next     = prm_rdata;
                prod_next  = PRW'(MW'(i_reg)) * PRW'(MW'(prm_rdata));
                state_next = ST_MARK;
            end

            ST_MARK:
            begin
                if (prod_reg >= PRW'(lim_reg))
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    fac_we    = 1'b1;
                    fac_waddr = AW'(prod_reg);
                    fac_wdata = p_reg;
                    // The first listed prime that divides i is its smallest factor.
                    if ((p_reg == f_reg) || (SCW'(j_reg) + SCW'(1) == stored_reg))
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        j_next     = j_reg + PW'(1);
                        state_next = ST_RD_P;
                    end
                end
            end

            ST_NEXT:
            begin
                i_next = i_reg + LW'(1);
                if (i_reg + LW'(1) == lim_reg)
                begin
                    built_next     = 1'b1;
                    built_lim_next = lim_reg;
                    res_valid      = 1'b1;
                    res.status     = STATUS_BUILT;
                    res.count      = total_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD_I;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/linear_prime_sieve_table.sv */
// Top level of the linear prime sieve table: stream ports, limit register, result register.
//
//  Channel  | Direction | Beat contents (lowest bit first)
//  ---------+-----------+--------------------------------------------------------
//  s_*      | in        | tuser: opcode; tdata: query_value[15:0]
//  m_*      | out       | tuser: status; tdata: smallest_factor, primes_up_to, pad
//  cfg_*    | in        | cfg_wr_data: sieve_limit[16:0], written when cfg_wr_en
//
// A refused query (not built, out of range) is answered from the idle state, any other query
// after the registered read of the factor and count memories. A build runs a clearing sweep
// over L values (L being the saturated limit), then reads and checks each value, with a read,
// multiply and mark per listed prime tried; the last try's product usually passes L.
// No clearing pass runs after reset: queries are refused until the first build. One item is
// worked on at a time, and a stalled result register holds off the input side.
module linear_prime_sieve_table #(
    parameter int VALUE_LIMIT = lpst_pkg::DEF_VALUE_LIMIT,
    parameter int PRIME_SLOTS = lpst_pkg::DEF_PRIME_SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,     // query_value[15:0]
    input  logic                       s_tuser,     // opcode[0]

    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,     // smallest_factor[15:0], primes_up_to[29:16]
    output logic [1:0]                 m_tuser,     // status[1:0]

    input  logic                       cfg_wr_en,
    input  logic [lpst_pkg::CFG_W-1:0] cfg_wr_data
);

    import lpst_pkg::*;

    logic [CFG_W-1:0] limit_reg;
    logic             out_valid_reg;
    res_t             out_reg;
    logic             out_free;
    logic             res_valid;
    res_t             res;

    // The limit register only takes effect when the next build starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // The result register is free when empty or when its beat is taken this cycle.
    assign out_free = !out_valid_reg || m_tready;

    lpst_ctrl #(
        .VALUE_LIMIT (VALUE_LIMIT),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .opcode      (opcode_t'(s_tuser)),
        .query_value (s_tdata),
        .sieve_limit (limit_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.count, out_reg.factor};
    assign m_tuser  = out_reg.status;

endmodule

/* hw/rtl/lpst_checker.sv */
// Port-level checks on the linear prime sieve table, bound to the top level.
module lpst_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [31:0]                m_tdata,
    input logic [1:0]                 m_tuser
);

    import lpst_pkg::*;

    // A stalled result beat holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

    // No input beat is taken while a result waits without being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

    // A build always runs the clearing sweep, so the input is closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_BUILD) |=> !s_tready)
    else $error("input open right after a build was taken");

    // Refused queries carry zero fields, and a build reports no factor.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == STATUS_NOT_BUILT) || (m_tuser == STATUS_RANGE))
        |-> (m_tdata == 32'd0))
    else $error("refused query carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_BUILT) |-> (m_tdata[15:0] == 16'd0))
    else $error("build result carries a factor");

endmodule

bind linear_prime_sieve_table lpst_checker u_lpst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
);

/* tb/tb_linear_prime_sieve_table.sv */
// Self-checking testbench for the linear prime sieve table: directed table, then random phases.
`timescale 1ns / 100ps

module tb_linear_prime_sieve_table;

    import lpst_pkg::*;

    localparam int VL = DEF_VALUE_LIMIT;
    localparam int PS = DEF_PRIME_SLOTS;

    // A full-size build is a clearing sweep plus a walk over every value and its prime tries, so
    // two of them dominate the run. The limit is several times the slowest correct run.
    localparam int CYCLE_LIMIT = 10_000_000;

    // The receiver holds its ready low this long once, so that the block backs up.
    localparam int LONG_HOLD = 300;

    localparam int DIR_N = 24;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BEATS = 104;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;      // query_value[15:0]
    logic                s_tuser = 1'b0;    // opcode[0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;           // smallest_factor[15:0], primes_up_to[29:16], pad
    logic [1:0]          m_tuser;           // status[1:0]
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;

    linear_prime_sieve_table #(
        .VALUE_LIMIT (VL),
        .PRIME_SLOTS (PS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns period, high then low.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Sieve predictor. It keeps its own copy of the tables and of the limit register, and
    // is stepped once for every beat that the block accepts on its input side.
    // ------------------------------------------------------------------------------------
    logic [VALUE_W-1:0] spf_tab   [0:VL-1];   // smallest prime factor per value
    logic [COUNT_W-1:0] cnt_tab   [0:VL-1];   // primes not above each value
    logic [VALUE_W-1:0] prime_tab [0:PS-1];   // primes in the order they were found
    bit                 built = 1'b0;
    int unsigned        built_lim = 0;
    logic [CFG_W-1:0]   limit_reg = LIMIT_RESET;

    function automatic int unsigned clamp_limit(input logic [CFG_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > VL)
            return VL;
        return v;
    endfunction

    function automatic res_t predict_beat(input opcode_t op, input logic [VALUE_W-1:0] v);
        res_t               r;
        int unsigned        lim;
        int unsigned        stored;
        int unsigned        i;
        int unsigned        j;
        int unsigned        p;
        longint unsigned    prod;
        logic [COUNT_W-1:0] total;
        r = '0;
        if (op == OP_BUILD)
        begin
            lim = clamp_limit(limit_reg);
            stored = 0;
            total = '0;
            for (i = 0; i < VL; i++)
                spf_tab[i] = '0;
            cnt_tab[0] = '0;
            cnt_tab[1] = '0;
            for (i = 2; i < lim; i++)
            begin
                if (spf_tab[i] == '0)
                begin
                    spf_tab[i] = VALUE_W'(i);
                    total = total + 14'd1;
                    // A prime beyond the list size is counted but never used for marking.
                    if (stored < PS)
                    begin
                        prime_tab[stored] = VALUE_W'(i);
                        stored++;
                    end
                end
                // Each composite is marked once, by its smallest prime factor.
                for (j = 0; j < stored; j++)
                begin
                    p = prime_tab[j];
                    prod = 64'(i) * 64'(p);
                    if (prod >= lim)
                        break;
                    spf_tab[prod[15:0]] = VALUE_W'(p);
                    if (i % p == 0)
                        break;
                end
                cnt_tab[i] = total;
            end
            built_lim = lim;
            built = 1'b1;
            r.status = STATUS_BUILT;
            r.count = total;
        end
        else if (!built)
            r.status = STATUS_NOT_BUILT;
        else if (v >= built_lim)
            r.status = STATUS_RANGE;   // compared with the limit of the last build
        else
        begin
            r.factor = spf_tab[v];
            r.count = cnt_tab[v];
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Directed table. Rows with a typed result carry values that follow directly from the
    // definition; the rest are checked against the predictor. A row may first write the
    // limit register, which is done only once the block has gone quiet.
    // ------------------------------------------------------------------------------------
    typedef struct {
        bit               wr_cfg;
        logic [CFG_W-1:0] cfg_val;
        opcode_t          op;
        logic [15:0]      value;
        bit               typed;
        status_t          st;
        logic [15:0]      factor;
        logic [13:0]      count;
    } dir_row_t;

    dir_row_t dir_tab [0:DIR_N-1] = '{
        // Queries before any build are refused.
        '{0, 17'd0,      OP_QUERY, 16'd0,     1, STATUS_NOT_BUILT, 16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'hFFFF,  1, STATUS_NOT_BUILT, 16'd0, 14'd0},
        // Build at the reset limit: all 6542 primes below 65536.
        '{0, 17'd0,      OP_BUILD, 16'h1234,  1, STATUS_BUILT,     16'd0, 14'd6542},
        '{0, 17'd0,      OP_QUERY, 16'd0,     1, STATUS_OK,        16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd1,     1, STATUS_OK,        16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd2,     1, STATUS_OK,        16'd2, 14'd1},
        '{0, 17'd0,      OP_QUERY, 16'hFFFF,  1, STATUS_OK,        16'd3, 14'd6542},
        '{0, 17'd0,      OP_QUERY, 16'd65521, 0, STATUS_OK,        16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd32768, 0, STATUS_OK,        16'd0, 14'd0},
        // A new limit of 1 leaves the last build in force until the next build.
        '{1, 17'd1,      OP_QUERY, 16'd100,   0, STATUS_OK,        16'd0, 14'd0},
        // That limit saturates to 2: nothing is sieved.
        '{0, 17'd0,      OP_BUILD, 16'hFFFF,  1, STATUS_BUILT,     16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd0,     1, STATUS_OK,        16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd1,     1, STATUS_OK,        16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd2,     1, STATUS_RANGE,     16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'hFFFF,  1, STATUS_RANGE,     16'd0, 14'd0},
        '{1, 17'd0,      OP_BUILD, 16'd0,     1, STATUS_BUILT,     16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd1,     0, STATUS_OK,        16'd0, 14'd0},
        '{1, 17'd3,      OP_BUILD, 16'd7,     1, STATUS_BUILT,     16'd0, 14'd1},
        '{0, 17'd0,      OP_QUERY, 16'd2,     1, STATUS_OK,        16'd2, 14'd1},
        '{0, 17'd0,      OP_QUERY, 16'd3,     1, STATUS_RANGE,     16'd0, 14'd0},
        // The largest register value saturates to the full table.
        '{1, 17'h1FFFF,  OP_QUERY, 16'd4097,  0, STATUS_OK,        16'd0, 14'd0},
        '{0, 17'd0,      OP_BUILD, 16'h8000,  1, STATUS_BUILT,     16'd0, 14'd6542},
        '{0, 17'd0,      OP_QUERY, 16'hFFFF,  0, STATUS_OK,        16'd0, 14'd0},
        '{0, 17'd0,      OP_QUERY, 16'd49999, 0, STATUS_OK,        16'd0, 14'd0}
    };

    // ------------------------------------------------------------------------------------
    // Bookkeeping shared by the processes below.
    // ------------------------------------------------------------------------------------
    res_t        sieve_results [$];   // results still owed by the block, oldest first
    bit          row_typed = 1'b0;    // the beat on offer carries a typed result
    res_t        row_exp = '0;
    int unsigned mismatches = 0;
    int unsigned beats_in = 0;
    int unsigned results_checked = 0;
    int unsigned builds_seen = 0;
    int unsigned long_holds = 0;
    int unsigned cycle_count = 0;
    bit          hold_long = 1'b0;    // asks the receiver for one long hold-off
    bit          tx_fast = 1'b0;
    int unsigned tx_run = 0;
    bit          rx_fast = 1'b0;
    int unsigned rx_run = 0;

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("tb: mismatch in %s: got %0d, wanted %0d (result %0d, cycle %0d)",
                 what, got, want, results_checked, cycle_count);
        mismatches++;
    endtask

    // Both handshakes are sampled at the rising edge. An output beat is compared with the
    // oldest expectation; an input beat steps the predictor and queues what it should give.
    always @(posedge clk)
    begin : beat_watch
        res_t want;
        res_t pred;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sieve_results.size() == 0)
                flag_mismatch("result beat with nothing pending", m_tdata[15:0], 0);
            else
            begin
                want = sieve_results.pop_front();
                if (m_tdata[15:0] !== want.factor)
                    flag_mismatch("smallest_factor", m_tdata[15:0], want.factor);
                if (m_tdata[29:16] !== want.count)
                    flag_mismatch("primes_up_to", m_tdata[29:16], want.count);
                if (m_tuser !== want.status)
                    flag_mismatch("status", m_tuser, want.status);
                results_checked++;
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            pred = predict_beat(opcode_t'(s_tuser), s_tdata);
            sieve_results.insert(sieve_results.size(), row_typed ? row_exp : pred);
            beats_in++;
            if (opcode_t'(s_tuser) == OP_BUILD)
                builds_seen++;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver. Before each beat it waits a drawn number of cycles with ready low, with
    // stretches of no waiting at all, and once it holds off for a long stretch on request.
    initial
    begin : result_sink
        int unsigned wait_n;
        forever
        begin
            if (rx_run == 0)
            begin
                rx_fast = ($urandom_range(0, 3) == 0);
                rx_run = $urandom_range(5, 30);
            end
            rx_run--;
            wait_n = rx_fast ? 0 : $urandom_range(0, 17);
            if (hold_long)
            begin
                wait_n = LONG_HOLD;
                hold_long = 1'b0;
                long_holds++;
            end
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Offers one beat after a drawn gap and returns at the falling edge after it was taken.
    // With no gap the valid simply stays high and only the payload changes.
    task automatic offer_beat(input opcode_t op, input logic [15:0] v, input bit typed,
                              input res_t exp);
        int unsigned gap;
        if (tx_run == 0)
        begin
            tx_fast = ($urandom_range(0, 3) == 0);
            tx_run = $urandom_range(5, 30);
        end
        tx_run--;
        gap = tx_fast ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= v;
        row_typed = typed;
        row_exp = exp;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Stops offering, waits for every owed result and lets the block settle.
    task automatic await_drain();
        s_tvalid <= 1'b0;
        while (sieve_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] v);
        await_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        limit_reg = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Main sequence: reset, the directed table, then random phases. Each phase sets a new
    // limit, asks a few queries against the previous tables, builds, and then queries the
    // new tables, mostly inside the sieved range and sometimes at or beyond its edge.
    initial
    begin : stimulus
        res_t             blank_res;
        res_t             row_want;
        logic [CFG_W-1:0] lim_pick;
        logic [15:0]      qv;
        int unsigned      span;
        int unsigned      pre;
        int unsigned      r;
        blank_res = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        for (int k = 0; k < DIR_N; k++)
        begin
            if (dir_tab[k].wr_cfg)
                set_limit(dir_tab[k].cfg_val);
            row_want = '{status: dir_tab[k].st, count: dir_tab[k].count,
                         factor: dir_tab[k].factor};
            offer_beat(dir_tab[k].op, dir_tab[k].value, dir_tab[k].typed, row_want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            // Mostly small limits keep builds short; one phase sieves a few thousand values
            // and one lands on the saturated low end.
            if (ph == 1)
                lim_pick = CFG_W'($urandom_range(0, 2));
            else if (ph == 5)
                lim_pick = CFG_W'($urandom_range(2000, 6000));
            else
                lim_pick = CFG_W'($urandom_range(0, 700));
            set_limit(lim_pick);
            span = clamp_limit(lim_pick);
            pre = $urandom_range(0, 4);
            // In this phase the output side stalls while queries keep coming.
            if (ph == 2)
                hold_long = 1'b1;
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                // Here the sender pauses until the block has caught up completely.
                if (ph == 4 && k == PHASE_BEATS / 2)
                    await_drain();
                if (k == pre || $urandom_range(0, 49) == 0)
                    offer_beat(OP_BUILD, 16'($urandom()), 1'b0, blank_res);
                else
                begin
                    r = $urandom_range(0, 9);
                    if (r <= 5)
                        qv = 16'($urandom_range(0, span - 1));
                    else if (r == 6)
                        qv = 16'($urandom_range(0, 1) ? span - 1 : span);
                    else if (r == 7)
                        qv = 16'($urandom_range(span, 65535));
                    else if (r == 8)
                        qv = 16'($urandom());
                    else
                        qv = 16'($urandom_range(0, 3));
                    offer_beat(OP_QUERY, qv, 1'b0, blank_res);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sieve_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("tb: %0d beats offered and %0d results checked, %0d of them builds",
                 beats_in, results_checked, builds_seen);
        $display("tb: limits from saturated low to saturated high, %0d long output stall(s)",
                 long_holds);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
